// ----- hw/rtl/tws_pkg.sv -----
// Shared types, constants and a helper function for the two-wire stepper sequencer.
package tws_pkg;

	localparam int POS_W = 16;
	localparam int CFG_W = 16;
	localparam int REMAIN_W = 15;
	localparam int TICKS_W = 16;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_MOVE = 2'd1,
		CMD_OFF  = 2'd2
	} cmd_e;

	typedef enum logic {
		REG_STEPS_PER_REV = 1'b0,
		REG_STEP_INTERVAL = 1'b1
	} reg_idx_e;

	localparam logic [CFG_W-1:0] STEPS_PER_REV_RST = 16'd200;
	localparam logic [CFG_W-1:0] STEP_INTERVAL_RST = 16'd10;
	localparam logic [REMAIN_W-1:0] REMAIN_MAX = '1;
	localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

	typedef struct packed {
		logic [CFG_W-1:0] steps_per_rev;
		logic [CFG_W-1:0] step_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic signed [15:0] move_steps;
	} cmd_t;

	typedef struct packed {
		logic        wire_a;
		logic        wire_b;
		logic [15:0] position;
		logic        busy_res;
		logic        stepped;
	} res_t;

	// Wire levels {wire_a, wire_b} for each phase: 01, 11, 10, 00
	function automatic logic [1:0] phase_pattern(input logic [1:0] phase);
		logic [1:0] pat;
		unique case (phase)
			2'd0: pat = 2'b01;
			2'd1: pat = 2'b11;
			2'd2: pat = 2'b10;
			2'd3: pat = 2'b00;
			default: pat = 2'b00;
		endcase
		return pat;
	endfunction

endpackage

// ----- hw/rtl/tws_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one input item.
interface tws_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [15:0] move_steps;

	modport source (output valid, output command, output move_steps, input ready);
	modport sink (input valid, input command, input move_steps, output ready);
endinterface

// ----- hw/rtl/tws_res_if.sv -----
// Result channel: valid/ready handshake carrying one result item.
interface tws_res_if;
	logic        valid;
	logic        ready;
	logic        wire_a;
	logic        wire_b;
	logic [15:0] position;
	logic        busy_res;
	logic        stepped;

	modport source (output valid, output wire_a, output wire_b, output position,
		output busy_res, output stepped, input ready);
	modport sink (input valid, input wire_a, input wire_b, input position,
		input busy_res, input stepped, output ready);
endinterface

// ----- hw/rtl/tws_cfg_regs.sv -----
// Configuration register file: steps per revolution and step interval.
module tws_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [tws_pkg::CFG_W-1:0] cfg_wdata,
	output tws_pkg::cfg_t           cfg
);

	tws_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_per_rev    <= tws_pkg::STEPS_PER_REV_RST;
			cfg_q.step_interval_ms <= tws_pkg::STEP_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tws_pkg::REG_STEPS_PER_REV: cfg_q.steps_per_rev    <= cfg_wdata;
				tws_pkg::REG_STEP_INTERVAL: cfg_q.step_interval_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/tws_step_core.sv -----
// Sequencer state and next-state logic: tick counting, step timing, position wrap, phase.
module tws_step_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  tws_pkg::cmd_t  cmd,
	input  tws_pkg::cfg_t  cfg,
	output tws_pkg::res_t  res
);

	logic [tws_pkg::POS_W-1:0]    pos_q, pos_d;
	logic                         fwd_q, fwd_d;
	logic [tws_pkg::REMAIN_W-1:0] rem_q, rem_d;
	logic [tws_pkg::TICKS_W-1:0]  ticks_q, ticks_d;
	logic [1:0]                   wires_q, wires_d;
	logic                         stepped;

	logic [tws_pkg::POS_W-1:0]   wrap_n;
	logic [tws_pkg::POS_W-1:0]   pos_fwd;
	logic [tws_pkg::POS_W-1:0]   pos_rev_base;
	logic [tws_pkg::POS_W-1:0]   pos_step;
	logic [tws_pkg::TICKS_W-1:0] ticks_inc;
	logic [15:0]                 neg_mag;

	assign wrap_n = tws_pkg::POS_W'(cfg.steps_per_rev);
	assign pos_fwd = pos_q + 1'b1;
	assign pos_rev_base = (pos_q == '0) ? wrap_n : pos_q;
	assign pos_step = fwd_q ? ((pos_fwd == wrap_n) ? '0 : pos_fwd) : (pos_rev_base - 1'b1);

	// Saturate the elapsed tick count
	assign ticks_inc = (ticks_q != tws_pkg::TICKS_MAX) ? ticks_q + 1'b1 : ticks_q;
	assign neg_mag = 16'd0 - 16'(unsigned'(cmd.move_steps));

	always_comb begin
		pos_d   = pos_q;
		fwd_d   = fwd_q;
		rem_d   = rem_q;
		ticks_d = ticks_q;
		wires_d = wires_q;
		stepped = 1'b0;
		unique case (cmd.command)
			tws_pkg::CMD_TICK: begin
				if (rem_q != '0 && ticks_inc >= cfg.step_interval_ms) begin
					ticks_d = '0;
					pos_d   = pos_step;
					rem_d   = rem_q - 1'b1;
					wires_d = tws_pkg::phase_pattern(pos_step[1:0]);
					stepped = 1'b1;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			tws_pkg::CMD_MOVE: begin
				if (cmd.move_steps[15]) begin
					// most negative count clamps to the largest run
					rem_d = neg_mag[15] ? tws_pkg::REMAIN_MAX : neg_mag[14:0];
					fwd_d = 1'b0;
				end else begin
					rem_d = cmd.move_steps[14:0];
					if (cmd.move_steps[14:0] != '0) begin
						fwd_d = 1'b1;
					end
				end
			end
			tws_pkg::CMD_OFF: begin
				wires_d = 2'b00;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fwd_q   <= 1'b0;
			rem_q   <= '0;
			ticks_q <= tws_pkg::TICKS_MAX;
			wires_q <= 2'b00;
		end else if (accept) begin
			pos_q   <= pos_d;
			fwd_q   <= fwd_d;
			rem_q   <= rem_d;
			ticks_q <= ticks_d;
			wires_q <= wires_d;
		end
	end

	always_comb begin
		res.wire_a   = wires_d[1];
		res.wire_b   = wires_d[0];
		res.position = 16'(pos_d);
		res.busy_res = (rem_d != '0);
		res.stepped  = stepped;
	end

endmodule

// ----- hw/rtl/tws_out_stage.sv -----
// Result register: holds one finished result until the downstream side takes it.
module tws_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tws_pkg::res_t res_in,
	output logic          free,
	tws_res_if.source     res
);

	logic          valid_q;
	tws_pkg::res_t data_q;

	// Slot is free when empty or emptied in this cycle
	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_in;
		end
	end

	assign res.valid    = valid_q;
	assign res.wire_a   = data_q.wire_a;
	assign res.wire_b   = data_q.wire_b;
	assign res.position = data_q.position;
	assign res.busy_res = data_q.busy_res;
	assign res.stepped  = data_q.stepped;

endmodule

// ----- hw/rtl/two_wire_stepper_sequencer_top.sv -----
// A command's result is loaded into the result register at the clock edge that accepts it.
// Throughput: one command per cycle; cmd.ready stays high while the result register
// is empty or its result is taken in the same cycle.
// The step state and the result register update together in a single pass.
// Reset (arst_n low) clears position, run and wires, saturates the tick count,
// loads 200 steps per rev and a 10 ms interval, and empties the result register.
module two_wire_stepper_sequencer_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [tws_pkg::CFG_W-1:0] cfg_wdata,
	tws_cmd_if.sink                   cmd,
	tws_res_if.source                 res
);

	tws_pkg::cfg_t cfg;
	tws_pkg::cmd_t cmd_item;
	tws_pkg::res_t res_next;
	logic          free;
	logic          accept;

	assign cmd.ready = free;
	assign accept = cmd.valid && free;
	assign cmd_item.command = cmd.command;
	assign cmd_item.move_steps = cmd.move_steps;

	tws_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tws_step_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd_item),
		.cfg    (cfg),
		.res    (res_next)
	);

	tws_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.res_in (res_next),
		.free   (free),
		.res    (res)
	);

endmodule

// ----- hw/rtl/tws_checker.sv -----
// Port-level checks for the sequencer top, attached by bind.
module tws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic [15:0] move_steps,
	input logic        out_valid,
	input logic        out_ready,
	input logic        wire_a,
	input logic        wire_b,
	input logic [15:0] position,
	input logic        busy_res,
	input logic        stepped
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(stepped))
		else $error("result dropped or changed while stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted transaction produced no result");

	a_step_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stepped |->
			wire_a == (position[0] ^ position[1]) && wire_b == !position[1])
		else $error("wire phase does not match position after a step");

	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == tws_pkg::CMD_MOVE && move_steps != 16'd0 |=> busy_res)
		else $error("nonzero move did not start a run");

	a_off_low: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == tws_pkg::CMD_OFF |=> !wire_a && !wire_b)
		else $error("motor off left a wire high");

endmodule

bind two_wire_stepper_sequencer_top tws_checker u_tws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.command    (cmd.command),
	.move_steps (cmd.move_steps),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.wire_a     (res.wire_a),
	.wire_b     (res.wire_b),
	.position   (res.position),
	.busy_res   (res.busy_res),
	.stepped    (res.stepped)
);

// ----- sim/two_wire_stepper_sequencer_top_tb.sv -----
// Self-checking testbench for the two-wire stepper sequencer: moves, ticks and off commands.
`timescale 1ns / 100ps

module two_wire_stepper_sequencer_top_tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 1000;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int PHASE_COUNT = 9;
	localparam logic [tws_pkg::CFG_W-1:0] PHASE_STEPS_PER_REV [PHASE_COUNT] =
		'{16'd0, 16'd200, 16'd1, 16'd65535, 16'd7, 16'd4, 16'd37, 16'd65535, 16'd2};
	localparam logic [tws_pkg::CFG_W-1:0] PHASE_INTERVAL [PHASE_COUNT] =
		'{16'd1, 16'd10, 16'd0, 16'd0, 16'd2, 16'd3, 16'd4, 16'd65535, 16'd1};

	// Tracks the motor state and holds the results still owed by the block.
	class step_tracker;
		logic [tws_pkg::CFG_W-1:0] steps_per_rev = tws_pkg::STEPS_PER_REV_RST;
		logic [tws_pkg::CFG_W-1:0] step_interval = tws_pkg::STEP_INTERVAL_RST;
		logic [tws_pkg::POS_W-1:0] position = '0;
		logic forward = 1'b0;
		logic [tws_pkg::REMAIN_W-1:0] remaining = '0;
		logic [tws_pkg::TICKS_W-1:0] ticks_since_step = tws_pkg::TICKS_MAX;
		logic [1:0] wires = 2'b00;
		tws_pkg::res_t pending_results[$];
		int error_count = 0;
		int result_count = 0;

		function void set_register(tws_pkg::reg_idx_e idx, logic [tws_pkg::CFG_W-1:0] value);
			if (idx == tws_pkg::REG_STEPS_PER_REV) begin
				steps_per_rev = value;
			end else begin
				step_interval = value;
			end
		endfunction

		function void note_command(logic [1:0] command, logic [15:0] steps);
			tws_pkg::res_t want;
			logic [16:0] magnitude;
			logic stepped;
			stepped = 1'b0;
			case (command)
				tws_pkg::CMD_TICK: begin
					if (ticks_since_step != tws_pkg::TICKS_MAX)
						ticks_since_step = ticks_since_step + 1'b1;
					if (remaining != '0 && ticks_since_step >= step_interval) begin
						ticks_since_step = '0;
						stepped = 1'b1;
						if (forward) begin
							position = position + 1'b1;
							if (position == steps_per_rev)
								position = '0;
						end else begin
							// wrap below zero to the top of the revolution
							if (position == '0)
								position = steps_per_rev;
							position = position - 1'b1;
						end
						remaining = remaining - 1'b1;
						case (position[1:0])
							2'd0: wires = 2'b01;
							2'd1: wires = 2'b11;
							2'd2: wires = 2'b10;
							default: wires = 2'b00;
						endcase
					end
				end
				tws_pkg::CMD_MOVE: begin
					if (steps[15]) begin
						magnitude = 17'h10000 - {1'b0, steps};
						if (magnitude > {2'b00, tws_pkg::REMAIN_MAX})
							magnitude = {2'b00, tws_pkg::REMAIN_MAX};
						forward = 1'b0;
					end else begin
						magnitude = {1'b0, steps};
						// a zero count keeps the direction
						if (steps != '0)
							forward = 1'b1;
					end
					remaining = magnitude[tws_pkg::REMAIN_W-1:0];
				end
				tws_pkg::CMD_OFF: wires = 2'b00;
				default: ;
			endcase
			want.wire_a = wires[1];
			want.wire_b = wires[0];
			want.position = position;
			want.busy_res = (remaining != '0);
			want.stepped = stepped;
			pending_results.push_back(want);
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			error_count++;
		endtask

		task check_result(tws_pkg::res_t got);
			tws_pkg::res_t want;
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
					result_count));
				return;
			end
			want = pending_results.pop_front();
			if (got.wire_a !== want.wire_a)
				report_mismatch($sformatf("result %0d wire_a %b, want %b",
					result_count, got.wire_a, want.wire_a));
			if (got.wire_b !== want.wire_b)
				report_mismatch($sformatf("result %0d wire_b %b, want %b",
					result_count, got.wire_b, want.wire_b));
			if (got.position !== want.position)
				report_mismatch($sformatf("result %0d position %0d, want %0d",
					result_count, got.position, want.position));
			if (got.busy_res !== want.busy_res)
				report_mismatch($sformatf("result %0d busy_res %b, want %b",
					result_count, got.busy_res, want.busy_res));
			if (got.stepped !== want.stepped)
				report_mismatch($sformatf("result %0d stepped %b, want %b",
					result_count, got.stepped, want.stepped));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [tws_pkg::CFG_W-1:0] cfg_wdata;
	int send_idle_pct = 31;
	int recv_idle_pct = 46;
	int quiet_cycles = 0;
	step_tracker tracker = new();

	tws_cmd_if cmd_if();
	tws_res_if res_if();

	two_wire_stepper_sequencer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd_if),
		.res(res_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_command(input logic [1:0] command, input logic [15:0] steps);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.command <= command;
		cmd_if.move_steps <= steps;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		tracker.note_command(command, steps);
	endtask

	task automatic settle_and_drain();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		// let the last update land before touching the registers
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input tws_pkg::reg_idx_e idx,
		input logic [tws_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int pick;
		logic [1:0] command;
		logic [15:0] steps;
		logic [15:0] magnitude;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			steps = 16'($urandom);
			if (pick < 70) begin
				command = tws_pkg::CMD_TICK;
			end else if (pick < 86) begin
				command = tws_pkg::CMD_MOVE;
				pick = $urandom_range(99);
				// mostly short runs so that runs finish and restart often
				if (pick < 8) begin
					steps = '0;
				end else if (pick < 12) begin
					steps = 16'h8000;
				end else if (pick >= 22) begin
					magnitude = 16'($urandom_range(40, 1));
					steps = $urandom_range(1) ? -magnitude : magnitude;
				end
			end else if (pick < 94) begin
				command = tws_pkg::CMD_OFF;
			end else begin
				command = CMD_UNUSED;
			end
			send_command(command, steps);
		end
	endtask

	// Receiver: stall at random, driven on the falling edge.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		tws_pkg::res_t got;
		if (res_if.valid && res_if.ready) begin
			got.wire_a = res_if.wire_a;
			got.wire_b = res_if.wire_b;
			got.position = res_if.position;
			got.busy_res = res_if.busy_res;
			got.stepped = res_if.stepped;
			tracker.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tws_pkg::REG_STEPS_PER_REV;
		cfg_wdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.command = tws_pkg::CMD_TICK;
		cmd_if.move_steps = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset state, idle tick and the unused code
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(CMD_UNUSED, 16'hFFFF);

		// saturated tick count lets the first step through even at the longest interval
		settle_and_drain();
		write_register(tws_pkg::REG_STEPS_PER_REV, 16'd65535);
		write_register(tws_pkg::REG_STEP_INTERVAL, 16'd65535);
		send_command(tws_pkg::CMD_MOVE, 16'hFFFF);
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(tws_pkg::CMD_MOVE, 16'd2);
		send_command(tws_pkg::CMD_TICK, 16'h0000);

		// position now above the revolution size; step on every tick
		settle_and_drain();
		write_register(tws_pkg::REG_STEPS_PER_REV, 16'd4);
		write_register(tws_pkg::REG_STEP_INTERVAL, 16'd0);
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(tws_pkg::CMD_MOVE, 16'h7FFF);
		repeat (4) send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(tws_pkg::CMD_OFF, 16'h0000);
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(tws_pkg::CMD_MOVE, 16'h8000);
		repeat (2) send_command(tws_pkg::CMD_TICK, 16'h0000);
		// a zero count cancels the run and keeps reverse
		send_command(tws_pkg::CMD_MOVE, 16'hFFFF);
		send_command(tws_pkg::CMD_MOVE, 16'h0000);
		send_command(tws_pkg::CMD_TICK, 16'h0000);
		send_command(CMD_UNUSED, 16'h5A5A);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase == 3) begin
				send_idle_pct = 46;
				recv_idle_pct = 31;
			end else if (phase == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			settle_and_drain();
			write_register(tws_pkg::REG_STEPS_PER_REV, PHASE_STEPS_PER_REV[phase]);
			write_register(tws_pkg::REG_STEP_INTERVAL, PHASE_INTERVAL[phase]);
			run_random(ITEMS_PER_PHASE);
		end

		settle_and_drain();
		if (tracker.error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/tws_pkg.sv
hw/rtl/tws_cmd_if.sv
hw/rtl/tws_res_if.sv
hw/rtl/tws_cfg_regs.sv
hw/rtl/tws_step_core.sv
hw/rtl/tws_out_stage.sv
hw/rtl/two_wire_stepper_sequencer_top.sv
hw/rtl/tws_checker.sv
sim/two_wire_stepper_sequencer_top_tb.sv
